>>> rtl/core/cme_pkg.sv
// Shared types and constants for the CMAC mode engine.
`timescale 1ns / 1ps

package cme_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
	localparam int WORD_BITS   = 64;
	localparam int COUNT_BITS  = 5;

	// Reduction constant for doubling in GF(2^128)
	localparam logic [7:0] RB_CONST = 8'h87;
	// First byte of the padding on a short last block
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_KEY_HIGH = 1'b0,
		CFG_KEY_LOW  = 1'b1
	} cfg_index_t;

	// One message block request
	typedef struct packed {
		logic [WORD_BITS-1:0]  data_high;
		logic [WORD_BITS-1:0]  data_low;
		logic [COUNT_BITS-1:0] byte_count;
		logic                  last_block;
	} in_t;

	// One MAC result
	typedef struct packed {
		logic [WORD_BITS-1:0] mac_high;
		logic [WORD_BITS-1:0] mac_low;
		logic                 length_error;
	} out_t;

	// Chaining state handed between the datapath and the top level
	typedef struct packed {
		logic [BLOCK_BITS-1:0] chain;
		logic                  error_seen;
	} chain_state_t;

endpackage

>>> rtl/core/cme_block_datapath.sv
// Per-block CMAC datapath: masking, padding, subkeys, chain update and MAC.
`timescale 1ns / 1ps

module cme_block_datapath
	import cme_pkg::*;
(
	input  in_t                   blk,
	input  logic [BLOCK_BITS-1:0] key,
	input  chain_state_t          cur,
	output chain_state_t          nxt,
	output out_t                  mac
);

	logic [COUNT_BITS-1:0] count;
	logic                  is_full;
	logic [BLOCK_BITS-1:0] data;
	logic [BLOCK_BITS-1:0] masked;
	logic [BLOCK_BITS-1:0] padded;
	logic [BLOCK_BITS-1:0] k1;
	logic [BLOCK_BITS-1:0] k2;
	logic [BLOCK_BITS-1:0] last_in;
	logic [BLOCK_BITS-1:0] tag;

	// Clamp the count to a full block
	assign count   = (blk.byte_count > COUNT_BITS'(BLOCK_BYTES)) ?
		COUNT_BITS'(BLOCK_BYTES) : blk.byte_count;
	assign is_full = (count == COUNT_BITS'(BLOCK_BYTES));
	assign data    = {blk.data_high, blk.data_low};

	// Zero bytes past the count and place the pad byte right after them
	always_comb begin
		masked = '0;
		padded = '0;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (COUNT_BITS'(i) < count) begin
				masked[BLOCK_BITS-1-8*i -: 8] = data[BLOCK_BITS-1-8*i -: 8];
				padded[BLOCK_BITS-1-8*i -: 8] = data[BLOCK_BITS-1-8*i -: 8];
			end else if (COUNT_BITS'(i) == count) begin
				padded[BLOCK_BITS-1-8*i -: 8] = PAD_BYTE;
			end
		end
	end

	// Derive subkeys by doubling the key (stand-in cipher gives L = key)
	assign k1 = {key[BLOCK_BITS-2:0], 1'b0} ^
		(key[BLOCK_BITS-1] ? BLOCK_BITS'(RB_CONST) : '0);
	assign k2 = {k1[BLOCK_BITS-2:0], 1'b0} ^
		(k1[BLOCK_BITS-1] ? BLOCK_BITS'(RB_CONST) : '0);

	assign last_in = is_full ? (masked ^ k1) : (padded ^ k2);
	assign tag     = cur.chain ^ last_in ^ key;

	// Advance the chain, or clear it after the last block
	always_comb begin
		if (blk.last_block) begin
			nxt.chain      = '0;
			nxt.error_seen = 1'b0;
		end else begin
			nxt.chain      = cur.chain ^ masked ^ key;
			nxt.error_seen = cur.error_seen | ~is_full;
		end
	end

	assign mac.mac_high     = tag[BLOCK_BITS-1 -: WORD_BITS];
	assign mac.mac_low      = tag[WORD_BITS-1:0];
	assign mac.length_error = cur.error_seen;

endmodule

>>> rtl/core/cmac_mode_engine.sv
// Top level of the CMAC mode engine: handshakes, key registers and chain state.
`timescale 1ns / 1ps

// Computes a 128-bit CMAC over 16-byte message blocks using a stand-in cipher
// (block XOR key). Blocks are accepted one per cycle into an input register;
// the chain update and MAC are combinational XOR logic from there, so the
// sustained rate is one block per clock, and a MAC is loaded into the output
// register as its last block leaves the input register. Only the last block
// of a message gives a result; a stalled result register holds back the
// input register only when it carries a last block. Write key_high (index 0)
// and key_low (index 1) while the engine is idle.
module cmac_mode_engine
	import cme_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  cfg_index_t           cfg_index,
	input  logic [WORD_BITS-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data
);

	logic [WORD_BITS-1:0] key_high_q;
	logic [WORD_BITS-1:0] key_low_q;
	chain_state_t         state_q;
	chain_state_t         state_nxt;
	logic                 valid_s1;
	in_t                  blk_s1;
	out_t                 mac_comb;
	logic                 out_valid_q;
	out_t                 out_q;
	logic                 out_free;
	logic                 adv_s1;

	// Hold the key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Advance the input stage unless a last block waits on a full output
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!blk_s1.last_block || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			blk_s1 <= in_data;
		end
	end

	cme_block_datapath u_datapath (
		.blk (blk_s1),
		.key ({key_high_q, key_low_q}),
		.cur (state_q),
		.nxt (state_nxt),
		.mac (mac_comb)
	);

	// Update the chain as each block leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Load the result register from a last block; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && blk_s1.last_block) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && blk_s1.last_block) begin
			out_q <= mac_comb;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A last block leaves the chain and error flag cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && blk_s1.last_block |=> state_q == '0)
		else $error("chain not cleared after last block");

	// A short block that is not last marks the message in error
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !blk_s1.last_block && blk_s1.byte_count < COUNT_BITS'(BLOCK_BYTES)
		|=> state_q.error_seen)
		else $error("short inner block did not set error");

	// An empty input stage always takes a new request
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while empty");

	// A result appears only from a last block leaving the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q ##1 out_valid_q |-> $past(adv_s1 && blk_s1.last_block))
		else $error("result without a last block");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the CMAC mode engine: directed block table, then random messages.
`timescale 1ns / 1ps

module tb_top;
	import cme_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS   = 225;
	localparam int NUM_PHASES    = 6;
	localparam int TIMEOUT_NS    = 2_000_000;

	typedef struct {
		bit                    rekey;
		logic [BLOCK_BITS-1:0] key;
		in_t                   blk;
		bit                    has_want;
		out_t                  want;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n;
	logic                 cfg_write = 1'b0;
	cfg_index_t           cfg_index = CFG_KEY_HIGH;
	logic [WORD_BITS-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;

	// Typed expectation that rides along with the request being offered
	bit   row_has  = 1'b0;
	out_t row_want = '0;

	// Stall controls
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_reqs      = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	// Predictor state and expected MACs
	logic [BLOCK_BITS-1:0] key_model   = '0;
	logic [BLOCK_BITS-1:0] chain_model = '0;
	logic                  err_model   = 1'b0;
	out_t                  mac_q[$];
	int                    failures    = 0;
	int                    blocks_sent = 0;

	cmac_mode_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Double a 128-bit value in GF(2^128)
	function automatic logic [BLOCK_BITS-1:0] gf_double(input logic [BLOCK_BITS-1:0] v);
		gf_double = {v[BLOCK_BITS-2:0], 1'b0};
		if (v[BLOCK_BITS-1])
			gf_double[7:0] = gf_double[7:0] ^ RB_CONST;
	endfunction

	function automatic logic [WORD_BITS-1:0] rand_word();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic in_t mk_block(input logic [WORD_BITS-1:0] dh, input logic [WORD_BITS-1:0] dl,
			input logic [COUNT_BITS-1:0] cnt, input logic last);
		in_t b;
		b.data_high  = dh;
		b.data_low   = dl;
		b.byte_count = cnt;
		b.last_block = last;
		return b;
	endfunction

	function automatic out_t mk_mac(input logic [WORD_BITS-1:0] mh, input logic [WORD_BITS-1:0] ml,
			input logic err);
		out_t m;
		m.mac_high     = mh;
		m.mac_low      = ml;
		m.length_error = err;
		return m;
	endfunction

	function automatic dir_row_t dir_row(input bit rekey, input logic [BLOCK_BITS-1:0] key,
			input in_t blk, input bit has_want, input out_t want);
		dir_row_t r;
		r.rekey    = rekey;
		r.key      = key;
		r.blk      = blk;
		r.has_want = has_want;
		r.want     = want;
		return r;
	endfunction

	// Random block: mostly full inner blocks, any length on the last one
	function automatic in_t rand_block(input logic last);
		int pick;
		logic [COUNT_BITS-1:0] cnt;
		pick = $urandom_range(99);
		if (last)
			cnt = (pick < 40) ? 5'd16 : (pick < 50) ? 5'($urandom_range(31, 17)) :
				5'($urandom_range(15));
		else
			cnt = (pick < 8) ? 5'($urandom_range(15)) : (pick < 16) ? 5'($urandom_range(31, 17)) :
				5'd16;
		return mk_block(rand_word(), rand_word(), cnt, last);
	endfunction

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check MACs, predict from accepted requests, track key writes
	always @(posedge clk) begin : scoreboard
		int                    nbytes;
		logic [BLOCK_BITS-1:0] blk;
		logic [BLOCK_BITS-1:0] subkey;
		logic [BLOCK_BITS-1:0] mac;
		out_t                  got;
		out_t                  want;
		if (arst_n) begin
			// compare a delivered MAC with the oldest expectation
			if (out_valid && out_ready) begin
				got = out_data;
				if (mac_q.size() == 0) begin
					$error("unexpected MAC %h_%h length_error %b", got.mac_high, got.mac_low,
						got.length_error);
					failures++;
				end else begin
					want = mac_q.pop_front();
					if (got.mac_high !== want.mac_high) begin
						$error("mac_high: expected %h, got %h", want.mac_high, got.mac_high);
						failures++;
					end
					if (got.mac_low !== want.mac_low) begin
						$error("mac_low: expected %h, got %h", want.mac_low, got.mac_low);
						failures++;
					end
					if (got.length_error !== want.length_error) begin
						$error("length_error: expected %b, got %b", want.length_error,
							got.length_error);
						failures++;
					end
				end
			end
			// absorb an accepted block into the chain, emit on the last one
			if (in_valid && in_ready) begin
				nbytes = (in_data.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : int'(in_data.byte_count);
				blk = {in_data.data_high, in_data.data_low};
				if (nbytes < BLOCK_BYTES)
					blk = blk & ~({BLOCK_BITS{1'b1}} >> (8 * nbytes));
				if (!in_data.last_block) begin
					if (nbytes < BLOCK_BYTES)
						err_model = 1'b1;
					chain_model = chain_model ^ blk ^ key_model;
				end else begin
					subkey = gf_double(key_model);
					if (nbytes < BLOCK_BYTES) begin
						subkey = gf_double(subkey);
						blk = blk | ({PAD_BYTE, {(BLOCK_BITS-8){1'b0}}} >> (8 * nbytes));
					end
					mac = chain_model ^ blk ^ subkey ^ key_model;
					want = mk_mac(mac[BLOCK_BITS-1:WORD_BITS], mac[WORD_BITS-1:0], err_model);
					mac_q.push_back(row_has ? row_want : want);
					chain_model = '0;
					err_model = 1'b0;
				end
			end
			// track key writes
			if (cfg_write) begin
				case (cfg_index)
					CFG_KEY_HIGH: key_model[BLOCK_BITS-1:WORD_BITS] = cfg_data;
					CFG_KEY_LOW:  key_model[WORD_BITS-1:0] = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Offer one request and hold it until accepted; called and returns at a falling edge
	task automatic send_block(input in_t blk, input bit has_want, input out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= blk;
		row_has  <= has_want;
		row_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		blocks_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every MAC, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (mac_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic load_key(input logic [BLOCK_BITS-1:0] k);
		cfg_write <= 1'b1;
		cfg_index <= CFG_KEY_HIGH;
		cfg_data  <= k[BLOCK_BITS-1:WORD_BITS];
		@(negedge clk);
		cfg_index <= CFG_KEY_LOW;
		cfg_data  <= k[WORD_BITS-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// One message: some inner blocks, then the last one
	task automatic send_message();
		int nblk;
		nblk = ($urandom_range(3) == 0) ? $urandom_range(6) : $urandom_range(2);
		for (int i = 0; i < nblk; i++)
			send_block(rand_block(1'b0), 1'b0, '0);
		send_block(rand_block(1'b1), 1'b0, '0);
	endtask

	initial begin : stimulus
		localparam logic [WORD_BITS-1:0] DA = 64'h0123_4567_89AB_CDEF;
		localparam logic [WORD_BITS-1:0] DB = 64'hFEDC_BA98_7654_3210;
		localparam logic [WORD_BITS-1:0] PAD_HI = {PAD_BYTE, 56'h0};
		dir_row_t              rows[$];
		logic [BLOCK_BITS-1:0] phase_key;
		int                    phase_start;
		bit                    paused;

		// assert reset with a real falling edge, hold it, then release at a falling edge
		arst_n <= 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		load_key('0);

		// zero key: the MAC reads off the block directly
		rows.push_back(dir_row(0, '0, mk_block('0, '0, 5'd0, 1'b1), 1, mk_mac(PAD_HI, '0, 1'b0)));
		rows.push_back(dir_row(0, '0, mk_block('1, '1, 5'd16, 1'b1), 1, mk_mac('1, '1, 1'b0)));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd31, 1'b1), 1, mk_mac(DA, DB, 1'b0)));
		// short inner block: error flag, bytes past the count ignored
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd0, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DB, DA, 5'd0, 1'b1), 1, mk_mac(PAD_HI, '0, 1'b1)));
		rows.push_back(dir_row(0, '0, mk_block('1, '1, 5'd16, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd7, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd8, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DB, DA, 5'd15, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd16, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd1, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd8, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd15, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DB, DA, 5'd17, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block('1, '1, 5'd0, 1'b1), 0, '0));
		// all-ones key
		rows.push_back(dir_row(1, '1, mk_block('0, '0, 5'd0, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block('1, '1, 5'd16, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd16, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DB, DA, 5'd9, 1'b1), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd31, 1'b0), 0, '0));
		rows.push_back(dir_row(0, '0, mk_block(DA, DB, 5'd0, 1'b1), 0, '0));

		// walk the directed table
		foreach (rows[i]) begin
			if (rows[i].rekey) begin
				settle();
				load_key(rows[i].key);
			end
			send_block(rows[i].blk, rows[i].has_want, rows[i].want);
		end
		settle();

		// random messages over several keys and stall patterns
		paused = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
				default: begin send_idle_pct = 18; recv_stall_pct <= 18; end
			endcase
			case (p)
				0: phase_key = '1;
				1: phase_key = {1'b1, {(BLOCK_BITS-1){1'b0}}};
				2: phase_key = {1'b0, {(BLOCK_BITS-1){1'b1}}};
				default: phase_key = {rand_word(), rand_word()};
			endcase
			load_key(phase_key);
			phase_start = blocks_sent;
			// long receiver hold-off while single-block messages keep coming
			if (p == 0) begin
				hold_reqs <= hold_reqs + 1;
				repeat (8)
					send_block(rand_block(1'b1), 1'b0, '0);
			end
			while (blocks_sent < phase_start + PHASE_ITEMS) begin
				send_message();
				// pause the sender until every MAC is out
				if (p == 3 && !paused && blocks_sent > phase_start + 100) begin
					paused = 1'b1;
					settle();
				end
			end
			settle();
		end

		if (failures == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
